### rtl/core/fdtd_yee_3d_field_update_core_assert.svh
// ---------------------------------------------------------------------------
// FDTD Yee core assertion macros
// Shared property forms for the field update core checks.
// ---------------------------------------------------------------------------
`ifndef FDTD_YEE_3D_FIELD_UPDATE_CORE_ASSERT_SVH
`define FDTD_YEE_3D_FIELD_UPDATE_CORE_ASSERT_SVH

// same-cycle implication
`define FDTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdtd core check failed");

// next-cycle implication
`define FDTD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdtd core check failed");

`endif

### rtl/core/fdtd_pkg.sv
// ---------------------------------------------------------------------------
// FDTD Yee core package
// Grid sizing, codes, types and fixed-point helpers shared by the core.
// ---------------------------------------------------------------------------
package fdtd_pkg;

    localparam int GRID_X    = 8;
    localparam int GRID_Y    = 8;
    localparam int GRID_Z    = 8;
    localparam int FRAC_BITS = 16;

    localparam int DATA_W = 32;
    localparam int WIDE_W = 64;
    localparam int ACC_W  = DATA_W + 2;

    localparam int EXT_X   = GRID_X + 1;
    localparam int EXT_Y   = GRID_Y + 1;
    localparam int EXT_Z   = GRID_Z + 1;
    localparam int E_CELLS = EXT_X * EXT_Y * EXT_Z;
    localparam int H_CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int EA_W    = $clog2(E_CELLS);
    localparam int HA_W    = $clog2(H_CELLS);

    localparam int GRID_MAX = (GRID_X > GRID_Y) ?
                              ((GRID_X > GRID_Z) ? GRID_X : GRID_Z) :
                              ((GRID_Y > GRID_Z) ? GRID_Y : GRID_Z);
    localparam int CNT_W    = $clog2(GRID_MAX + 1);

    localparam int NUM_AXES  = 3;
    localparam int OP_W      = 2;
    localparam int COMP_W    = 3;
    localparam int CELL_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_REGS  = 8;

    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(1 << FRAC_BITS);

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd2;

    localparam logic [COMP_W-1:0] COMP_EX = 3'd0;
    localparam logic [COMP_W-1:0] COMP_EY = 3'd1;
    localparam logic [COMP_W-1:0] COMP_EZ = 3'd2;
    localparam logic [COMP_W-1:0] COMP_HX = 3'd3;
    localparam logic [COMP_W-1:0] COMP_HY = 3'd4;
    localparam logic [COMP_W-1:0] COMP_HZ = 3'd5;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_E_SCALE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_E_RETAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_H_COEF_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_H_COEF_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_H_COEF_Z = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DX   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DY   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_DZ   = 3'd7;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_RD,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_WB
    } core_state_t;

    typedef enum logic [2:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_TERM1,
        MAC_TERM2,
        MAC_TERM3,
        MAC_SCALE
    } mac_step_t;

    typedef struct packed {
        mac_step_t step;
        logic      neg1;
        logic      neg2;
    } mac_ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-DATA_W:0] hi;
        hi = v[WIDE_W-1:DATA_W-1];
        if ((&hi) || !(|hi))
            return v[DATA_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    function automatic logic [EA_W-1:0] eix(input logic [CNT_W-1:0] i,
                                            input logic [CNT_W-1:0] j,
                                            input logic [CNT_W-1:0] k);
        return EA_W'((int'(i) * EXT_Y + int'(j)) * EXT_Z + int'(k));
    endfunction

    function automatic logic [HA_W-1:0] hix(input logic [CNT_W-1:0] i,
                                            input logic [CNT_W-1:0] j,
                                            input logic [CNT_W-1:0] k);
        return HA_W'((int'(i) * GRID_Y + int'(j)) * GRID_Z + int'(k));
    endfunction

endpackage

### rtl/core/fdtd_ram.sv
// ---------------------------------------------------------------------------
// FDTD grid memory
// Synchronous RAM, one write port and two registered read ports.
// ---------------------------------------------------------------------------
module fdtd_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int WIDTH  = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [WIDTH-1:0]  rdata0,
    output logic [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata0_reg;
    logic [WIDTH-1:0] rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

### rtl/core/fdtd_mac.sv
// ---------------------------------------------------------------------------
// FDTD cell update datapath
// Shared Q-format multiplier and accumulator for one field component update.
// ---------------------------------------------------------------------------
module fdtd_mac
    import fdtd_pkg::*;
(
    input  logic                     clk,
    input  mac_ctrl_t                ctrl,
    input  logic signed [DATA_W-1:0] cur,
    input  logic signed [DATA_W-1:0] a_plus,
    input  logic signed [DATA_W-1:0] a_minus,
    input  logic signed [DATA_W-1:0] b_plus,
    input  logic signed [DATA_W-1:0] b_minus,
    input  logic signed [DATA_W-1:0] coef_0,
    input  logic signed [DATA_W-1:0] coef_a,
    input  logic signed [DATA_W-1:0] coef_b,
    input  logic signed [DATA_W-1:0] coef_s,
    output logic signed [DATA_W-1:0] result
);

    logic signed [DATA_W-1:0] da_reg, da_next;
    logic signed [DATA_W-1:0] db_reg, db_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [WIDE_W-1:0] prod_reg, prod_next;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic signed [WIDE_W-1:0] mult;
    logic signed [DATA_W-1:0] quot;
    logic signed [ACC_W-1:0]  quot_ext;
    logic signed [DATA_W-1:0] acc_sat;

    assign mult     = mul_a * mul_b;
    assign quot     = sat_wide(prod_reg >>> FRAC_BITS);
    assign quot_ext = ACC_W'(quot);
    assign acc_sat  = sat_wide(WIDE_W'(acc_reg));
    assign result   = quot;

    always_comb
    begin
        da_next   = da_reg;
        db_next   = db_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        mul_a     = coef_0;
        mul_b     = cur;
        case (ctrl.step)
            MAC_LOAD:
            begin
                da_next   = sat_wide(WIDE_W'(a_plus) - WIDE_W'(a_minus));
                db_next   = sat_wide(WIDE_W'(b_plus) - WIDE_W'(b_minus));
                prod_next = mult;
            end
            MAC_TERM1:
            begin
                acc_next  = quot_ext;
                mul_a     = coef_a;
                mul_b     = da_reg;
                prod_next = mult;
            end
            MAC_TERM2:
            begin
                acc_next  = ctrl.neg1 ? acc_reg - quot_ext : acc_reg + quot_ext;
                mul_a     = coef_b;
                mul_b     = db_reg;
                prod_next = mult;
            end
            MAC_TERM3:
            begin
                acc_next = ctrl.neg2 ? acc_reg - quot_ext : acc_reg + quot_ext;
            end
            MAC_SCALE:
            begin
                mul_a     = coef_s;
                mul_b     = acc_sat;
                prod_next = mult;
            end
            default:
            begin
                prod_next = prod_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        da_reg   <= da_next;
        db_reg   <= db_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
    end

endmodule

### rtl/core/fdtd_yee_3d_field_update_core.sv
// ---------------------------------------------------------------------------
// FDTD Yee 3-D field update core
// Six field grids in RAM, cell read/write and Yee time step in Q16.16.
//
//   channel  direction  signals
//   cfg      in         cfg_valid, cfg_ready, cfg_index, cfg_data
//   request  in         in_valid, in_ready, op, component, cell_x/y/z, write_value
//   result   out        out_valid, out_ready, read_value, status, steps_done
//
// Write, bad-index and no-op requests load the result register directly; a good
// read first passes ST_ACCESS. A time step runs ST_RD, ST_M0 to ST_M4 and ST_WB
// per component of every H cell, then of every interior E cell, on the single
// shared multiplier. After reset a clearing pass over all E_CELLS addresses
// zeroes the grids; no request is taken meanwhile, configuration writes are.
// A request is taken only while the result register is free or being drained.
// ---------------------------------------------------------------------------
`include "fdtd_yee_3d_field_update_core_assert.svh"

module fdtd_yee_3d_field_update_core
    import fdtd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DATA_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic [COMP_W-1:0]        component,
    input  logic [CELL_W-1:0]        cell_x,
    input  logic [CELL_W-1:0]        cell_y,
    input  logic [CELL_W-1:0]        cell_z,
    input  logic signed [DATA_W-1:0] write_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     status,
    output logic [DATA_W-1:0]        steps_done
);

    core_state_t state_reg, state_next;

    logic [EA_W-1:0]   clr_reg, clr_next;
    logic              phase_e_reg, phase_e_next;
    logic [1:0]        comp_reg, comp_next;
    logic [CNT_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic              rd_fam_e_reg, rd_fam_e_next;
    logic [1:0]        rd_sel_reg, rd_sel_next;
    logic [DATA_W-1:0] step_count_reg, step_count_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg, out_value_next;
    logic              out_status_reg, out_status_next;
    logic [DATA_W-1:0] out_steps_reg, out_steps_next;
    logic signed [DATA_W-1:0] cfg_reg [CFG_REGS];

    logic              in_fire;
    logic              is_e, is_h, e_in_range, h_in_range, cell_ok;
    logic [1:0]        comp_sel;
    logic [CNT_W-1:0]  cx, cy, cz;
    logic [EA_W-1:0]   in_e_addr;
    logic [HA_W-1:0]   in_h_addr;
    logic              clr_last, comp_last, cell_last, step_done;
    logic [CNT_W-1:0]  idx_lo;

    logic [1:0]        a_idx, b_idx;
    logic [EA_W-1:0]   e_c, e_ip, e_jp, e_kp, a_plus_e, b_plus_e;
    logic [HA_W-1:0]   h_c, h_im, h_jm, h_km, a_minus_h, b_minus_h;

    logic [EA_W-1:0]   e_ra0 [NUM_AXES];
    logic [EA_W-1:0]   e_ra1 [NUM_AXES];
    logic [HA_W-1:0]   h_ra0 [NUM_AXES];
    logic [HA_W-1:0]   h_ra1 [NUM_AXES];
    logic [DATA_W-1:0] e_rd0 [NUM_AXES];
    logic [DATA_W-1:0] e_rd1 [NUM_AXES];
    logic [DATA_W-1:0] h_rd0 [NUM_AXES];
    logic [DATA_W-1:0] h_rd1 [NUM_AXES];
    logic [2:0]        e_we, h_we;
    logic [5:0]        we_all;
    logic [EA_W-1:0]   e_wa;
    logic [HA_W-1:0]   h_wa;
    logic [DATA_W-1:0] wd;

    mac_ctrl_t                mac_ctrl;
    logic signed [DATA_W-1:0] m_cur, m_ap, m_am, m_bp, m_bm;
    logic signed [DATA_W-1:0] m_c0, m_ca, m_cb, m_cs, mac_result;

    // request decode
    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire    = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign is_e       = (component == COMP_EX) || (component == COMP_EY) ||
                        (component == COMP_EZ);
    assign is_h       = (component == COMP_HX) || (component == COMP_HY) ||
                        (component == COMP_HZ);
    assign e_in_range = (int'(cell_x) <= GRID_X) && (int'(cell_y) <= GRID_Y) &&
                        (int'(cell_z) <= GRID_Z);
    assign h_in_range = (int'(cell_x) < GRID_X) && (int'(cell_y) < GRID_Y) &&
                        (int'(cell_z) < GRID_Z);
    assign cell_ok    = (is_e && e_in_range) || (is_h && h_in_range);
    assign comp_sel   = is_e ? component[1:0] : 2'(component - COMP_HX);
    assign cx         = CNT_W'(cell_x);
    assign cy         = CNT_W'(cell_y);
    assign cz         = CNT_W'(cell_z);
    assign in_e_addr  = eix(cx, cy, cz);
    assign in_h_addr  = hix(cx, cy, cz);

    // sweep position
    assign clr_last  = (clr_reg == EA_W'(E_CELLS - 1));
    assign comp_last = (comp_reg == AX_Z);
    assign cell_last = (i_reg == CNT_W'(GRID_X - 1)) && (j_reg == CNT_W'(GRID_Y - 1)) &&
                       (k_reg == CNT_W'(GRID_Z - 1));
    assign step_done = comp_last && cell_last && phase_e_reg;
    assign idx_lo    = CNT_W'(phase_e_reg);

    assign e_c  = eix(i_reg, j_reg, k_reg);
    assign e_ip = eix(i_reg + CNT_W'(1), j_reg, k_reg);
    assign e_jp = eix(i_reg, j_reg + CNT_W'(1), k_reg);
    assign e_kp = eix(i_reg, j_reg, k_reg + CNT_W'(1));
    assign h_c  = hix(i_reg, j_reg, k_reg);
    assign h_im = hix(i_reg - CNT_W'(1), j_reg, k_reg);
    assign h_jm = hix(i_reg, j_reg - CNT_W'(1), k_reg);
    assign h_km = hix(i_reg, j_reg, k_reg - CNT_W'(1));

    // curl operand grids and neighbor addresses per component
    always_comb
    begin
        a_idx     = AX_Z;
        b_idx     = AX_Y;
        a_plus_e  = e_jp;
        b_plus_e  = e_kp;
        a_minus_h = h_jm;
        b_minus_h = h_km;
        m_ca      = phase_e_reg ? cfg_reg[CFG_INV_DY] : cfg_reg[CFG_H_COEF_Y];
        m_cb      = phase_e_reg ? cfg_reg[CFG_INV_DZ] : cfg_reg[CFG_H_COEF_Z];
        case (comp_reg)
            AX_Y:
            begin
                a_idx     = AX_X;
                b_idx     = AX_Z;
                a_plus_e  = e_kp;
                b_plus_e  = e_ip;
                a_minus_h = h_km;
                b_minus_h = h_im;
                m_ca      = phase_e_reg ? cfg_reg[CFG_INV_DZ] : cfg_reg[CFG_H_COEF_Z];
                m_cb      = phase_e_reg ? cfg_reg[CFG_INV_DX] : cfg_reg[CFG_H_COEF_X];
            end
            AX_Z:
            begin
                a_idx     = AX_Y;
                b_idx     = AX_X;
                a_plus_e  = e_ip;
                b_plus_e  = e_jp;
                a_minus_h = h_im;
                b_minus_h = h_jm;
                m_ca      = phase_e_reg ? cfg_reg[CFG_INV_DX] : cfg_reg[CFG_H_COEF_X];
                m_cb      = phase_e_reg ? cfg_reg[CFG_INV_DY] : cfg_reg[CFG_H_COEF_Y];
            end
            default:
            begin
                a_idx = AX_Z;
            end
        endcase
    end

    // read addresses
    always_comb
    begin
        for (int g = 0; g < NUM_AXES; g++)
        begin
            e_ra0[g] = in_e_addr;
            e_ra1[g] = in_e_addr;
            h_ra0[g] = in_h_addr;
            h_ra1[g] = in_h_addr;
        end
        if (state_reg != ST_IDLE)
        begin
            if (!phase_e_reg)
            begin
                e_ra0[a_idx]    = a_plus_e;
                e_ra1[a_idx]    = e_c;
                e_ra0[b_idx]    = b_plus_e;
                e_ra1[b_idx]    = e_c;
                h_ra0[comp_reg] = h_c;
            end
            else
            begin
                h_ra0[a_idx]    = h_c;
                h_ra1[a_idx]    = a_minus_h;
                h_ra0[b_idx]    = h_c;
                h_ra1[b_idx]    = b_minus_h;
                e_ra0[comp_reg] = e_c;
            end
        end
    end

    // write port
    always_comb
    begin
        e_we = '0;
        h_we = '0;
        e_wa = in_e_addr;
        h_wa = in_h_addr;
        wd   = write_value;
        case (state_reg)
            ST_CLEAR:
            begin
                e_we = '1;
                h_we = (int'(clr_reg) < H_CELLS) ? '1 : '0;
                e_wa = clr_reg;
                h_wa = HA_W'(clr_reg);
                wd   = '0;
            end
            ST_IDLE:
            begin
                if (in_fire && (op == OP_WRITE) && cell_ok)
                begin
                    if (is_e)
                        e_we[comp_sel] = 1'b1;
                    else
                        h_we[comp_sel] = 1'b1;
                end
            end
            ST_WB:
            begin
                e_wa = e_c;
                h_wa = h_c;
                wd   = mac_result;
                if (phase_e_reg)
                    e_we[comp_reg] = 1'b1;
                else
                    h_we[comp_reg] = 1'b1;
            end
            default:
            begin
                wd = write_value;
            end
        endcase
    end

    assign we_all = {e_we, h_we};

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_e_ram
        fdtd_ram #(
            .DEPTH  (E_CELLS),
            .ADDR_W (EA_W),
            .WIDTH  (DATA_W)
        ) u_ram (
            .clk    (clk),
            .we     (e_we[g]),
            .waddr  (e_wa),
            .wdata  (wd),
            .raddr0 (e_ra0[g]),
            .raddr1 (e_ra1[g]),
            .rdata0 (e_rd0[g]),
            .rdata1 (e_rd1[g])
        );
    end

    for (genvar g = 0; g < NUM_AXES; g++)
    begin : g_h_ram
        fdtd_ram #(
            .DEPTH  (H_CELLS),
            .ADDR_W (HA_W),
            .WIDTH  (DATA_W)
        ) u_ram (
            .clk    (clk),
            .we     (h_we[g]),
            .waddr  (h_wa),
            .wdata  (wd),
            .raddr0 (h_ra0[g]),
            .raddr1 (h_ra1[g]),
            .rdata0 (h_rd0[g]),
            .rdata1 (h_rd1[g])
        );
    end

    // datapath operands
    assign m_cur = phase_e_reg ? e_rd0[comp_reg] : h_rd0[comp_reg];
    assign m_ap  = phase_e_reg ? h_rd0[a_idx] : e_rd0[a_idx];
    assign m_am  = phase_e_reg ? h_rd1[a_idx] : e_rd1[a_idx];
    assign m_bp  = phase_e_reg ? h_rd0[b_idx] : e_rd0[b_idx];
    assign m_bm  = phase_e_reg ? h_rd1[b_idx] : e_rd1[b_idx];
    assign m_c0  = phase_e_reg ? cfg_reg[CFG_E_RETAIN] : Q_ONE;
    assign m_cs  = phase_e_reg ? cfg_reg[CFG_E_SCALE] : Q_ONE;

    fdtd_mac u_mac (
        .clk     (clk),
        .ctrl    (mac_ctrl),
        .cur     (m_cur),
        .a_plus  (m_ap),
        .a_minus (m_am),
        .b_plus  (m_bp),
        .b_minus (m_bm),
        .coef_0  (m_c0),
        .coef_a  (m_ca),
        .coef_b  (m_cb),
        .coef_s  (m_cs),
        .result  (mac_result)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire && (op == OP_READ) && cell_ok)
                    state_next = ST_ACCESS;
                else if (in_fire && (op == OP_STEP))
                    state_next = ST_RD;
            end
            ST_ACCESS: state_next = ST_IDLE;
            ST_RD:     state_next = ST_M0;
            ST_M0:     state_next = ST_M1;
            ST_M1:     state_next = ST_M2;
            ST_M2:     state_next = ST_M3;
            ST_M3:     state_next = ST_M4;
            ST_M4:     state_next = ST_WB;
            ST_WB:     state_next = step_done ? ST_IDLE : ST_RD;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        clr_next        = clr_reg;
        phase_e_next    = phase_e_reg;
        comp_next       = comp_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        rd_fam_e_next   = rd_fam_e_reg;
        rd_sel_next     = rd_sel_reg;
        step_count_next = step_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_steps_next  = out_steps_reg;
        mac_ctrl.step   = MAC_HOLD;
        mac_ctrl.neg1   = !phase_e_reg;
        mac_ctrl.neg2   = phase_e_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + EA_W'(1);
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_STEP)
                    begin
                        phase_e_next = 1'b0;
                        comp_next    = AX_X;
                        i_next       = '0;
                        j_next       = '0;
                        k_next       = '0;
                    end
                    else if ((op == OP_READ) && cell_ok)
                    begin
                        rd_fam_e_next = is_e;
                        rd_sel_next   = comp_sel;
                    end
                    else
                    begin
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = ((op == OP_WRITE) || (op == OP_READ)) && !cell_ok;
                        out_steps_next  = step_count_reg;
                    end
                end
            end
            ST_ACCESS:
            begin
                out_valid_next  = 1'b1;
                out_value_next  = rd_fam_e_reg ? e_rd0[rd_sel_reg] : h_rd0[rd_sel_reg];
                out_status_next = 1'b0;
                out_steps_next  = step_count_reg;
            end
            ST_RD:
            begin
                mac_ctrl.step = MAC_HOLD;
            end
            ST_M0: mac_ctrl.step = MAC_LOAD;
            ST_M1: mac_ctrl.step = MAC_TERM1;
            ST_M2: mac_ctrl.step = MAC_TERM2;
            ST_M3: mac_ctrl.step = MAC_TERM3;
            ST_M4: mac_ctrl.step = MAC_SCALE;
            ST_WB:
            begin
                if (!comp_last)
                begin
                    comp_next = comp_reg + 2'd1;
                end
                else
                begin
                    comp_next = AX_X;
                    if (k_reg != CNT_W'(GRID_Z - 1))
                    begin
                        k_next = k_reg + CNT_W'(1);
                    end
                    else
                    begin
                        k_next = idx_lo;
                        if (j_reg != CNT_W'(GRID_Y - 1))
                        begin
                            j_next = j_reg + CNT_W'(1);
                        end
                        else
                        begin
                            j_next = idx_lo;
                            i_next = (i_reg != CNT_W'(GRID_X - 1)) ? i_reg + CNT_W'(1) : idx_lo;
                        end
                    end
                    if (cell_last && !phase_e_reg)
                    begin
                        phase_e_next = 1'b1;
                        i_next       = CNT_W'(1);
                        j_next       = CNT_W'(1);
                        k_next       = CNT_W'(1);
                    end
                    if (step_done)
                    begin
                        step_count_next = step_count_reg + DATA_W'(1);
                        out_valid_next  = 1'b1;
                        out_value_next  = '0;
                        out_status_next = 1'b0;
                        out_steps_next  = step_count_reg + DATA_W'(1);
                    end
                end
            end
            default:
            begin
                mac_ctrl.step = MAC_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            phase_e_reg    <= 1'b0;
            comp_reg       <= AX_X;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            rd_fam_e_reg   <= 1'b0;
            rd_sel_reg     <= AX_X;
            step_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int r = 0; r < CFG_REGS; r++)
            begin
                cfg_reg[r] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            phase_e_reg    <= phase_e_next;
            comp_reg       <= comp_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            rd_fam_e_reg   <= rd_fam_e_next;
            rd_sel_reg     <= rd_sel_next;
            step_count_reg <= step_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_steps_reg  <= out_steps_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign status     = out_status_reg;
    assign steps_done = out_steps_reg;

    `FDTD_ASSERT_IMP(a_wb_single_write, state_reg == ST_WB, $onehot(we_all))
    `FDTD_ASSERT_IMP(a_no_write_in_math, (state_reg != ST_WB) && (state_reg != ST_CLEAR) && (state_reg != ST_IDLE), we_all == 6'd0)
    `FDTD_ASSERT_NXT(a_access_result, state_reg == ST_ACCESS, out_valid_reg)
    `FDTD_ASSERT_NXT(a_step_count, (state_reg == ST_WB) && step_done, step_count_reg == $past(step_count_reg) + 32'd1)

endmodule
